>>> src/hpsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsv_pkg - shared types and constants of the Hough pattern shift voter
// Operation codes, fixed port widths and the flag bundle of the shared unit.
// ----------------------------------------------------------------------------
package hpsv_pkg;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 10;
  localparam int OFFSET_W = 7;
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 16;
  localparam int TOTAL_W  = 11;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 3'd0,
    OP_SEED     = 3'd1,
    OP_REGISTER = 3'd2,
    OP_VOTE     = 3'd3,
    OP_READ     = 3'd4
  } op_code_t;

  typedef struct packed {
    logic ge;
    logic zero;
  } alu_flags_t;

endpackage

>>> src/hpsv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsv_ram - simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hpsv_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/hpsv_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsv_alu - shared add / wrap unit
// Adds two operands and, when wrapping, folds the sum once below a modulus.
// ----------------------------------------------------------------------------
module hpsv_alu
  import hpsv_pkg::*;
#(
  parameter int UW = 16
) (
  input  logic [UW-1:0] a,
  input  logic [UW-1:0] b,
  input  logic [UW-1:0] m,
  input  logic          wrap,
  output logic [UW-1:0] sum,
  output alu_flags_t    flags
);

  logic [UW-1:0] raw;

  always_comb begin
    raw        = a + b;
    flags.ge   = (raw >= m);
    flags.zero = (raw == '0);
    sum        = (wrap && flags.ge) ? raw - m : raw;
  end

endmodule

>>> src/hough_pattern_shift_voter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hough_pattern_shift_voter - Hough plane vote counters with pattern voting
// Sequencer over a counter memory, a pattern list memory and one add unit.
// ----------------------------------------------------------------------------
// An operation is transferred when start is high and busy is low; its single
// result appears on cell_value and pattern_total for exactly one cycle with
// done high, and cannot be held off. Clear writes one counter per cell,
// register reads the counter memory once per cell plus a tail compare, and
// vote reduces the column shift (column_offset-1, 0 when column_offset is 0)
// modulo NUM_COLUMNS by repeated subtraction, forms it, and then handles each
// pattern entry with a list read, a counter read and a counter write through
// the shared adder. done is high in the first cycle in which busy is low
// again. Unused codes and out-of-plane seed/read never raise busy and answer
// in the next cycle. After reset busy stays high while the counter memory is
// cleared.
module hough_pattern_shift_voter
  import hpsv_pkg::*;
#(
  parameter int NUM_COLUMNS = 64,
  parameter int NUM_ROWS    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            operation,
  input  logic [INDEX_W-1:0]         cell_index,
  input  logic [OFFSET_W-1:0]        column_offset,
  input  logic signed [WEIGHT_W-1:0] weight,
  output logic                       done,
  output logic signed [VALUE_W-1:0]  cell_value,
  output logic [TOTAL_W-1:0]         pattern_total
);

  localparam int CELLS  = NUM_COLUMNS * NUM_ROWS;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int UW     = (COUNT_WIDTH > CELL_AW + 1) ? COUNT_WIDTH : CELL_AW + 1;
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(CELLS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED_RD,
    S_SEED_WR,
    S_READ_RD,
    S_READ_OUT,
    S_REG,
    S_REG_TAIL,
    S_VOTE_COL,
    S_VOTE_SHIFT,
    S_VOTE_LIST,
    S_VOTE_CELL,
    S_VOTE_ADD
  } state_t;

  state_t              state;
  logic                init_pass;
  logic [CELL_AW-1:0]  idx;
  logic [CELL_AW-1:0]  addr;
  logic [CELL_AW-1:0]  cmp_addr;
  logic                cmp_valid;
  logic [CNT_W-1:0]    pcount;
  logic [CNT_W-1:0]    pcount_next;
  logic [OFFSET_W-1:0] col;
  logic [CELL_AW-1:0]  shift;
  logic [UW-1:0]       wt;

  logic                   accept;
  logic                   cell_we;
  logic [CELL_AW-1:0]     cell_waddr;
  logic [COUNT_WIDTH-1:0] cell_wdata;
  logic [CELL_AW-1:0]     cell_raddr;
  logic [COUNT_WIDTH-1:0] cell_rdata;
  logic                   list_we;
  logic [CELL_AW-1:0]     list_rdata;

  logic [UW-1:0] alu_a;
  logic [UW-1:0] alu_b;
  logic [UW-1:0] alu_m;
  logic          alu_wrap;
  logic [UW-1:0] alu_sum;
  alu_flags_t    alu_flags;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  hpsv_ram #(
    .DEPTH (CELLS),
    .AW    (CELL_AW),
    .DW    (COUNT_WIDTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  hpsv_ram #(
    .DEPTH (CELLS),
    .AW    (CELL_AW),
    .DW    (CELL_AW)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (pcount[CELL_AW-1:0]),
    .wdata (cmp_addr),
    .raddr (idx),
    .rdata (list_rdata)
  );

  hpsv_alu #(
    .UW (UW)
  ) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .m     (alu_m),
    .wrap  (alu_wrap),
    .sum   (alu_sum),
    .flags (alu_flags)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a    = '0;
    alu_b    = '0;
    alu_m    = '0;
    alu_wrap = 1'b0;
    case (state)
      S_VOTE_COL: begin
        alu_a    = UW'(col);
        alu_m    = UW'(NUM_COLUMNS);
        alu_wrap = 1'b1;
      end
      S_VOTE_CELL: begin
        alu_a    = UW'(list_rdata);
        alu_b    = UW'(shift);
        alu_m    = UW'(CELLS);
        alu_wrap = 1'b1;
      end
      S_SEED_WR, S_VOTE_ADD: begin
        alu_a = UW'(cell_rdata);
        alu_b = wt;
      end
      S_REG, S_REG_TAIL: begin
        alu_a = UW'(cell_rdata);
      end
      default: begin
      end
    endcase
  end

  // memory port control
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = idx;
    cell_wdata = '0;
    cell_raddr = idx;
    case (state)
      S_CLEAR: begin
        cell_we = 1'b1;
      end
      S_SEED_RD, S_READ_RD: begin
        cell_raddr = addr;
      end
      S_SEED_WR, S_VOTE_ADD: begin
        cell_we    = 1'b1;
        cell_waddr = addr;
        cell_wdata = alu_sum[COUNT_WIDTH-1:0];
      end
      S_VOTE_CELL: begin
        cell_raddr = alu_sum[CELL_AW-1:0];
      end
      default: begin
      end
    endcase

    // record the previous cell when its counter is nonzero
    list_we = (state == S_REG || state == S_REG_TAIL) && cmp_valid && !alu_flags.zero;

    if (accept && operation == OP_REGISTER) begin
      pcount_next = '0;
    end else if (list_we) begin
      pcount_next = pcount + CNT_W'(1);
    end else begin
      pcount_next = pcount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init_pass <= 1'b1;
      idx       <= '0;
      cmp_valid <= 1'b0;
      pcount    <= '0;
      done      <= 1'b0;
    end else begin
      done   <= 1'b0;
      pcount <= pcount_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr       <= CELL_AW'(cell_index);
            wt         <= UW'(weight);
            idx        <= '0;
            cmp_valid  <= 1'b0;
            cell_value <= '0;
            col        <= (column_offset == '0) ? '0 : column_offset - OFFSET_W'(1);
            case (operation)
              OP_CLEAR: begin
                state <= S_CLEAR;
              end
              OP_SEED: begin
                if (32'(cell_index) < CELLS) begin
                  state <= S_SEED_RD;
                end else begin
                  done          <= 1'b1;
                  pattern_total <= TOTAL_W'(pcount_next);
                end
              end
              OP_READ: begin
                if (32'(cell_index) < CELLS) begin
                  state <= S_READ_RD;
                end else begin
                  done          <= 1'b1;
                  pattern_total <= TOTAL_W'(pcount_next);
                end
              end
              OP_REGISTER: begin
                state <= S_REG;
              end
              OP_VOTE: begin
                state <= S_VOTE_COL;
              end
              default: begin
                done          <= 1'b1;
                pattern_total <= TOTAL_W'(pcount_next);
              end
            endcase
          end
        end

        S_CLEAR: begin
          idx <= idx + CELL_AW'(1);
          if (idx == LAST_CELL) begin
            idx   <= '0;
            state <= S_IDLE;
            if (init_pass) begin
              init_pass <= 1'b0;
            end else begin
              done          <= 1'b1;
              pattern_total <= TOTAL_W'(pcount_next);
            end
          end
        end

        S_SEED_RD: begin
          state <= S_SEED_WR;
        end

        S_SEED_WR: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          pattern_total <= TOTAL_W'(pcount_next);
        end

        S_READ_RD: begin
          state <= S_READ_OUT;
        end

        S_READ_OUT: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          cell_value    <= VALUE_W'(signed'(cell_rdata));
          pattern_total <= TOTAL_W'(pcount_next);
        end

        S_REG: begin
          cmp_valid <= 1'b1;
          cmp_addr  <= idx;
          idx       <= idx + CELL_AW'(1);
          if (idx == LAST_CELL) begin
            state <= S_REG_TAIL;
          end
        end

        S_REG_TAIL: begin
          idx           <= '0;
          cmp_valid     <= 1'b0;
          state         <= S_IDLE;
          done          <= 1'b1;
          pattern_total <= TOTAL_W'(pcount_next);
        end

        // reduce the column shift modulo the plane width, one subtract a cycle
        S_VOTE_COL: begin
          if (alu_flags.ge) begin
            col <= alu_sum[OFFSET_W-1:0];
          end else begin
            state <= S_VOTE_SHIFT;
          end
        end

        S_VOTE_SHIFT: begin
          shift <= CELL_AW'(32'(col) * NUM_ROWS);
          idx   <= '0;
          if (pcount == '0) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            pattern_total <= TOTAL_W'(pcount_next);
          end else begin
            state <= S_VOTE_LIST;
          end
        end

        S_VOTE_LIST: begin
          state <= S_VOTE_CELL;
        end

        S_VOTE_CELL: begin
          addr  <= alu_sum[CELL_AW-1:0];
          state <= S_VOTE_ADD;
        end

        S_VOTE_ADD: begin
          if (CNT_W'(idx) + CNT_W'(1) == pcount) begin
            idx           <= '0;
            state         <= S_IDLE;
            done          <= 1'b1;
            pattern_total <= TOTAL_W'(pcount_next);
          end else begin
            idx   <= idx + CELL_AW'(1);
            state <= S_VOTE_LIST;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the Hough pattern shift voter
// Queued operations are driven through the start/busy command port while a
// monitor predicts every transfer against a local copy of the vote plane and
// checks each done strobe in order. Directed corner cases come first, then
// random seed/register/vote/read sequences mixed with noise operations.
// ----------------------------------------------------------------------------
module tb_top;
  import hpsv_pkg::*;

  localparam int NUM_COLUMNS = 64;
  localparam int NUM_ROWS    = 16;
  localparam int COUNT_W     = 16;
  localparam int NUM_CELLS   = NUM_COLUMNS * NUM_ROWS;
  localparam int RANDOM_OPS  = 420;
  // longest quiet stretch is a vote over a full pattern
  localparam int IDLE_LIMIT  = 20000;

  localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;

  typedef struct {
    logic [OP_W-1:0]            op;
    logic [INDEX_W-1:0]         index;
    logic [OFFSET_W-1:0]        offset;
    logic signed [WEIGHT_W-1:0] weight;
    int                         gap;
    bit                         drain;
  } plane_cmd_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [TOTAL_W-1:0]        total;
  } plane_reply_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [OP_W-1:0]            operation = '0;
  logic [INDEX_W-1:0]         cell_index = '0;
  logic [OFFSET_W-1:0]        column_offset = '0;
  logic signed [WEIGHT_W-1:0] weight = '0;
  logic                       done;
  logic signed [VALUE_W-1:0]  cell_value;
  logic [TOTAL_W-1:0]         pattern_total;

  hough_pattern_shift_voter #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS),
    .COUNT_WIDTH (COUNT_W)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .cell_index    (cell_index),
    .column_offset (column_offset),
    .weight        (weight),
    .done          (done),
    .cell_value    (cell_value),
    .pattern_total (pattern_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the plane
  logic signed [COUNT_W-1:0] plane_counts [NUM_CELLS];
  logic [INDEX_W-1:0]        pattern_cells [NUM_CELLS];
  int unsigned               pattern_len = 0;

  plane_cmd_t   cmd_backlog [$];
  plane_reply_t predicted_replies [$];
  int           replies_owed = 0;
  int           ops_taken = 0;
  int           total_ops = 0;
  int           fail_count = 0;
  int           gap_count = 0;
  int           idle_cycles = 0;

  initial begin
    for (int i = 0; i < NUM_CELLS; i++) plane_counts[i] = '0;
  end

  function automatic plane_reply_t apply_to_plane(plane_cmd_t c);
    plane_reply_t r;
    int unsigned  shift;
    int unsigned  target;
    r.value = '0;
    case (c.op)
      OP_CLEAR: begin
        for (int i = 0; i < NUM_CELLS; i++) plane_counts[i] = '0;
      end
      OP_SEED: begin
        if (c.index < NUM_CELLS) plane_counts[c.index] = plane_counts[c.index] + c.weight;
      end
      OP_REGISTER: begin
        pattern_len = 0;
        for (int i = 0; i < NUM_CELLS; i++) begin
          if (plane_counts[i] != 0) begin
            pattern_cells[pattern_len] = INDEX_W'(i);
            pattern_len++;
          end
        end
      end
      OP_VOTE: begin
        shift = (c.offset != 0) ? ((int'(c.offset) - 1) * NUM_ROWS) % NUM_CELLS : 0;
        for (int unsigned i = 0; i < pattern_len; i++) begin
          target = (int'(pattern_cells[i]) % NUM_CELLS) + shift;
          if (target >= NUM_CELLS) target -= NUM_CELLS;
          plane_counts[target] = plane_counts[target] + c.weight;
        end
      end
      OP_READ: begin
        if (c.index < NUM_CELLS) r.value = plane_counts[c.index];
      end
      default: ;
    endcase
    r.total = TOTAL_W'(pattern_len);
    return r;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] rand_weight();
    return WEIGHT_W'($urandom);
  endfunction

  function automatic logic [INDEX_W-1:0] rand_index();
    return INDEX_W'($urandom);
  endfunction

  function automatic logic [OFFSET_W-1:0] rand_offset();
    return OFFSET_W'($urandom);
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic [INDEX_W-1:0] index,
                                    logic [OFFSET_W-1:0] offset,
                                    logic signed [WEIGHT_W-1:0] w, int gap_max,
                                    bit drain);
    plane_cmd_t c;
    c.op     = op;
    c.index  = index;
    c.offset = offset;
    c.weight = w;
    c.gap    = $urandom_range(0, gap_max);
    c.drain  = drain;
    cmd_backlog.push_back(c);
  endfunction

  // driver: present the next operation and hold it until busy drops
  always @(posedge clk) begin : drive_proc
    bit         sent;
    bit         go;
    plane_cmd_t nxt;
    sent = start && !busy;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
      gap_count = 0;
    end else if (!(start && !sent)) begin
      if (cmd_backlog.size() != 0) begin
        if (gap_count < cmd_backlog[0].gap) begin
          gap_count++;
        end else if (!cmd_backlog[0].drain || (!sent && replies_owed == 0)) begin
          nxt = cmd_backlog.pop_front();
          go = 1'b1;
          gap_count = 0;
          operation     <= nxt.op;
          cell_index    <= nxt.index;
          column_offset <= nxt.offset;
          weight        <= nxt.weight;
        end
      end
      start <= go;
    end
  end

  // monitor: check the strobed reply first, then predict the new transfer
  always @(posedge clk) begin : monitor_proc
    plane_cmd_t   seen;
    plane_reply_t want;
    if (!rst) begin
      if (done) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected reply, cell_value %0d pattern_total %0d",
                   $time, cell_value, pattern_total);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (cell_value !== want.value) begin
            $display("%0t: cell_value mismatch, expected %0d, actual %0d",
                     $time, want.value, cell_value);
            fail_count++;
          end
          if (pattern_total !== want.total) begin
            $display("%0t: pattern_total mismatch, expected %0d, actual %0d",
                     $time, want.total, pattern_total);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        seen.op     = operation;
        seen.index  = cell_index;
        seen.offset = column_offset;
        seen.weight = weight;
        predicted_replies.push_back(apply_to_plane(seen));
        ops_taken <= ops_taken + 1;
      end
      replies_owed <= predicted_replies.size();
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int                  directed_ops;
    int                  gmax;
    int                  n_seed;
    int                  n_vote;
    bit                  broad_done;
    logic [INDEX_W-1:0]  seeded [8];
    logic [INDEX_W-1:0]  idx;

    // directed corners
    queue_cmd(OP_READ, 10'd0, 7'd0, 16'sd0, 0, 1'b0);
    queue_cmd(OP_VOTE, 10'd5, 7'd0, 16'sd5, 0, 1'b0);        // empty pattern
    queue_cmd(OP_REGISTER, 10'd0, 7'd0, 16'sd0, 0, 1'b0);    // nothing nonzero
    queue_cmd(OP_SEED, 10'd0, 7'd0, 16'sd32767, 0, 1'b0);
    queue_cmd(OP_SEED, 10'd0, 7'd0, 16'sd1, 2, 1'b0);        // wraps to most negative
    queue_cmd(OP_READ, 10'd0, 7'd0, 16'sd0, 0, 1'b0);
    queue_cmd(OP_SEED, 10'd1023, 7'd127, -16'sd32768, 0, 1'b0);
    queue_cmd(OP_READ, 10'd1023, 7'd0, 16'sd0, 1, 1'b0);
    queue_cmd(OP_SEED, 10'd17, 7'd0, 16'sd3, 0, 1'b0);
    queue_cmd(OP_SEED, 10'd17, 7'd0, -16'sd3, 0, 1'b0);      // back to zero
    queue_cmd(OP_REGISTER, 10'd1023, 7'd127, -16'sd1, 0, 1'b0);
    queue_cmd(OP_VOTE, 10'd0, 7'd0, 16'sd1, 0, 1'b0);
    queue_cmd(OP_VOTE, 10'd0, 7'd1, -16'sd1, 3, 1'b0);
    queue_cmd(OP_VOTE, 10'd0, 7'd2, 16'sd7, 0, 1'b0);        // last column wraps
    queue_cmd(OP_VOTE, 10'd0, 7'd64, 16'sd11, 0, 1'b0);
    queue_cmd(OP_VOTE, 10'd0, 7'd65, 16'sd13, 4, 1'b0);      // full turn
    queue_cmd(OP_VOTE, 10'd0, 7'd127, 16'sd17, 0, 1'b0);
    queue_cmd(OP_READ, 10'd15, 7'd0, 16'sd0, 0, 1'b0);
    queue_cmd(OP_READ, 10'd1023, 7'd0, 16'sd0, 0, 1'b0);
    queue_cmd(OP_READ, 10'd0, 7'd0, 16'sd0, 0, 1'b0);
    for (int k = OP_READ + 1; k <= OP_SPARE_LAST; k++) begin
      queue_cmd(OP_W'(k), rand_index(), rand_offset(), rand_weight(), 1, 1'b0);
    end
    queue_cmd(OP_CLEAR, 10'd0, 7'd0, 16'sd0, 0, 1'b1);       // pattern kept
    queue_cmd(OP_READ, 10'd15, 7'd0, 16'sd0, 0, 1'b0);
    queue_cmd(OP_REGISTER, 10'd0, 7'd0, 16'sd0, 0, 1'b0);
    directed_ops = cmd_backlog.size();

    broad_done = 1'b0;
    while (cmd_backlog.size() < directed_ops + RANDOM_OPS) begin
      gmax = ($urandom_range(0, 2) == 0) ? 0 : 4;
      if (!broad_done && cmd_backlog.size() > directed_ops + RANDOM_OPS / 2) begin
        // grow the pattern by doubling until it covers the whole plane
        broad_done = 1'b1;
        queue_cmd(OP_CLEAR, rand_index(), rand_offset(), rand_weight(), gmax, 1'b1);
        for (int r = 0; r < NUM_ROWS; r++) begin
          queue_cmd(OP_SEED, INDEX_W'(r), rand_offset(), 16'sd1, gmax, 1'b0);
        end
        queue_cmd(OP_REGISTER, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
        for (int w = 1; w < NUM_COLUMNS; w = w * 2) begin
          queue_cmd(OP_VOTE, rand_index(), OFFSET_W'(w + 1), 16'sd1, gmax, 1'b0);
          queue_cmd(OP_REGISTER, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
        end
        queue_cmd(OP_VOTE, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
        queue_cmd(OP_READ, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
        queue_cmd(OP_CLEAR, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
      end else if ($urandom_range(0, 9) < 7) begin
        queue_cmd(OP_CLEAR, rand_index(), rand_offset(), rand_weight(), gmax,
                  $urandom_range(0, 3) == 0);
        n_seed = $urandom_range(1, 6);
        for (int k = 0; k < n_seed; k++) begin
          seeded[k] = rand_index();
          queue_cmd(OP_SEED, seeded[k], rand_offset(), rand_weight(), gmax, 1'b0);
        end
        queue_cmd(OP_REGISTER, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
        n_vote = $urandom_range(1, 5);
        for (int k = 0; k < n_vote; k++) begin
          queue_cmd(OP_VOTE, rand_index(), rand_offset(), rand_weight(), gmax, 1'b0);
          for (int j = $urandom_range(1, 2); j > 0; j--) begin
            // aim reads at cells a shifted pattern lands on
            idx = INDEX_W'((int'(seeded[$urandom_range(0, n_seed - 1)]) +
                            NUM_ROWS * $urandom_range(0, NUM_COLUMNS - 1)) % NUM_CELLS);
            queue_cmd(OP_READ, idx, rand_offset(), rand_weight(), gmax, 1'b0);
          end
        end
      end else begin
        for (int k = $urandom_range(3, 8); k > 0; k--) begin
          queue_cmd(OP_W'($urandom_range(0, OP_SPARE_LAST)), rand_index(), rand_offset(),
                    rand_weight(), gmax, 1'b0);
        end
      end
    end
    total_ops = cmd_backlog.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (ops_taken != total_ops || replies_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, predicted_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
